@@ rtl/core/literal_token_classifier_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Literal token classifier assertion macros
// Shared assertion forms used by the classifier's RTL.
// ----------------------------------------------------------------------------
`ifndef LITERAL_TOKEN_CLASSIFIER_UNIT_DEFINES_SVH
`define LITERAL_TOKEN_CLASSIFIER_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LTC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define LTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/ltc_pkg.sv @@
// ----------------------------------------------------------------------------
// Literal token classifier package
// Types, constants and per-byte recognizer functions.
// ----------------------------------------------------------------------------
package ltc_pkg;

    localparam int MAX_PART_LEN = 255;
    localparam int LEN_W        = $clog2(MAX_PART_LEN + 3);
    localparam int TOK_LEN_W    = 9;

    typedef enum logic [2:0] {
        CLS_INT     = 3'd0,
        CLS_CHAR    = 3'd1,
        CLS_STRING  = 3'd2,
        CLS_REAL    = 3'd3,
        CLS_COMPLEX = 3'd4,
        CLS_LOGICAL = 3'd5,
        CLS_UNKNOWN = 3'd6
    } lit_class_t;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_LEFT  = 2'd1,
        PH_RIGHT = 2'd2,
        PH_NONE  = 2'd3
    } cx_phase_t;

    typedef enum logic [4:0] {
        N_START, N_SIGN, N_ZERO, N_DIG, N_DOT0, N_FRAC, N_EXP, N_ESGN,
        N_EDIG, N_HX, N_HDOT0, N_HINT, N_HFRAC, N_HP, N_HPSGN, N_HPDIG,
        N_I1, N_I2, N_I3, N_I4, N_I5, N_I6, N_I7, N_I8,
        N_N1, N_N2, N_N3, N_NP, N_NC, N_DEAD
    } num_st_t;

    typedef struct packed {
        logic    trail;
        logic    mark;
        num_st_t st;
    } num_t;

    typedef struct packed {
        num_t             run;
        num_t             run_prev;
        num_t             cut;
        logic             has_us;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] cut_len;
    } seg_t;

    localparam num_t NUM_RESET = '{trail: 1'b0, mark: 1'b0, st: N_START};

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex(input logic [7:0] l);
        return is_dig(l) || (l >= "a" && l <= "f");
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_sgn(input logic [7:0] c);
        return c == "+" || c == "-";
    endfunction

    function automatic num_st_t num_lead(input logic [7:0] c, input logic [7:0] l);
        if (c == "0") return N_ZERO;
        if (is_dig(c)) return N_DIG;
        if (c == ".") return N_DOT0;
        if (l == "i") return N_I1;
        if (l == "n") return N_N1;
        return N_DEAD;
    endfunction

    // Expected letter after each partial match of the word infinity.
    function automatic logic [7:0] inf_char(input num_st_t s);
        logic [7:0] r;
        case (s)
            N_I1:    r = "n";
            N_I2:    r = "f";
            N_I3:    r = "i";
            N_I4:    r = "n";
            N_I5:    r = "i";
            N_I6:    r = "t";
            default: r = "y";
        endcase
        return r;
    endfunction

    function automatic num_t num_next(input num_t cur, input logic [7:0] c);
        num_t    r;
        logic [7:0] l;
        logic    d;
        num_st_t n;
        l = to_lower(c);
        d = is_dig(c);
        r = cur;
        n = N_DEAD;
        if (c == "." || l == "e") r.mark = 1'b1;
        if (cur.st == N_DEAD) begin
            r.st = N_DEAD;
        end else if (cur.trail) begin
            r.st = is_ws(c) ? cur.st : N_DEAD;
        end else if (is_ws(c)) begin
            if (cur.st != N_START) r.trail = 1'b1;
        end else begin
            case (cur.st)
                N_START: n = is_sgn(c) ? N_SIGN : num_lead(c, l);
                N_SIGN:  n = num_lead(c, l);
                N_ZERO:  n = d ? N_DIG : c == "." ? N_FRAC : l == "e" ? N_EXP :
                             l == "x" ? N_HX : N_DEAD;
                N_DIG:   n = d ? N_DIG : c == "." ? N_FRAC : l == "e" ? N_EXP : N_DEAD;
                N_DOT0:  n = d ? N_FRAC : N_DEAD;
                N_FRAC:  n = d ? N_FRAC : l == "e" ? N_EXP : N_DEAD;
                N_EXP:   n = is_sgn(c) ? N_ESGN : d ? N_EDIG : N_DEAD;
                N_ESGN, N_EDIG: n = d ? N_EDIG : N_DEAD;
                N_HX:    n = is_hex(l) ? N_HINT : c == "." ? N_HDOT0 : N_DEAD;
                N_HDOT0: n = is_hex(l) ? N_HFRAC : N_DEAD;
                N_HINT:  n = is_hex(l) ? N_HINT : c == "." ? N_HFRAC :
                             l == "p" ? N_HP : N_DEAD;
                N_HFRAC: n = is_hex(l) ? N_HFRAC : l == "p" ? N_HP : N_DEAD;
                N_HP:    n = is_sgn(c) ? N_HPSGN : d ? N_HPDIG : N_DEAD;
                N_HPSGN, N_HPDIG: n = d ? N_HPDIG : N_DEAD;
                N_I1, N_I2, N_I3, N_I4, N_I5, N_I6, N_I7:
                    n = (l == inf_char(cur.st)) ? num_st_t'(cur.st + 5'd1) : N_DEAD;
                N_N1:    n = l == "a" ? N_N2 : N_DEAD;
                N_N2:    n = l == "n" ? N_N3 : N_DEAD;
                N_N3:    n = c == "(" ? N_NP : N_DEAD;
                N_NP:    n = (d || (l >= "a" && l <= "z") || c == "_") ? N_NP :
                             c == ")" ? N_NC : N_DEAD;
                default: n = N_DEAD;
            endcase
            r.st = n;
        end
        return r;
    endfunction

    function automatic logic real_accept(input num_st_t s);
        return s == N_ZERO || s == N_DIG || s == N_FRAC || s == N_EDIG || s == N_HINT ||
               s == N_HFRAC || s == N_HPDIG || s == N_I3 || s == N_I8 || s == N_N3 ||
               s == N_NC;
    endfunction

    // Bit 0: integer syntax; bit 1: real syntax.
    function automatic logic [1:0] seg_eval(input seg_t g, input logic use_prev,
                                            input logic allow_trail);
        num_t       s;
        logic       allow;
        logic [1:0] r;
        s     = g.has_us ? g.cut : (use_prev ? g.run_prev : g.run);
        allow = g.has_us ? 1'b0 : allow_trail;
        r     = 2'b00;
        if (!(s.trail && !allow)) begin
            r[0] = s.st == N_ZERO || s.st == N_DIG;
            r[1] = s.mark && real_accept(s.st);
        end
        return r;
    endfunction

    // Letter expected at each position of .true. and .false.
    function automatic logic [7:0] true_char(input logic [TOK_LEN_W-1:0] p);
        logic [7:0] r;
        case (p)
            9'd1:    r = "t";
            9'd2:    r = "r";
            9'd3:    r = "u";
            9'd4:    r = "e";
            default: r = ".";
        endcase
        return r;
    endfunction

    function automatic logic [7:0] false_char(input logic [TOK_LEN_W-1:0] p);
        logic [7:0] r;
        case (p)
            9'd1:    r = "f";
            9'd2:    r = "a";
            9'd3:    r = "l";
            9'd4:    r = "s";
            9'd5:    r = "e";
            default: r = ".";
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/ltc_in_if.sv @@
// ----------------------------------------------------------------------------
// Token byte channel
// Valid/ready channel carrying one token byte and its end flag.
// ----------------------------------------------------------------------------
interface ltc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_token;

    modport source (output valid, output char_code, output end_of_token, input ready);
    modport sink   (input valid, input char_code, input end_of_token, output ready);
endinterface

@@ rtl/core/ltc_out_if.sv @@
// ----------------------------------------------------------------------------
// Literal class channel
// Valid/ready channel carrying the class of one finished token.
// ----------------------------------------------------------------------------
interface ltc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] literal_class;

    modport source (output valid, output literal_class, input ready);
    modport sink   (input valid, input literal_class, output ready);
endinterface

@@ rtl/core/ltc_seg.sv @@
// ----------------------------------------------------------------------------
// Numeric segment recognizer
// Tracks number syntax, last underscore and length over one byte stream.
// ----------------------------------------------------------------------------
module ltc_seg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          feed,
    input  logic          clear,
    input  logic [7:0]    char_code,
    output ltc_pkg::seg_t seg_next
);
    ltc_pkg::seg_t seg_reg;
    ltc_pkg::seg_t seg_fed;
    ltc_pkg::seg_t seg_clr;

    always_comb
    begin
        seg_clr = '{run: ltc_pkg::NUM_RESET, run_prev: ltc_pkg::NUM_RESET,
                    cut: ltc_pkg::NUM_RESET, has_us: 1'b0, len: '0, cut_len: '0};
        seg_fed = seg_reg;
        if (char_code == "_")
        begin
            seg_fed.cut     = seg_reg.run;
            seg_fed.cut_len = seg_reg.len;
            seg_fed.has_us  = 1'b1;
        end
        seg_fed.run_prev = seg_reg.run;
        seg_fed.run      = ltc_pkg::num_next(seg_reg.run, char_code);
        if (seg_reg.len < ltc_pkg::LEN_W'(ltc_pkg::MAX_PART_LEN + 2))
            seg_fed.len = seg_reg.len + 1'b1;
        seg_next = feed ? seg_fed : seg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_reg <= seg_clr;
        else if (clear)
            seg_reg <= seg_clr;
        else
            seg_reg <= seg_next;
    end
endmodule

@@ rtl/core/literal_token_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// Literal token classifier
// Streams token bytes and reports the literal class of each finished token.
// ----------------------------------------------------------------------------
// The tok channel takes one byte of a token per item; end_of_token marks its
// final byte. The res channel gives one item per token, carrying the class:
// int, character, string, real, complex, logical or unknown. Bytes that are
// not final produce no result.
// Each accepted byte lands in an input register. When the byte moves on, the
// token state (length, first byte, logical word match, and three number
// recognizers for the whole token and both complex parts) is advanced, and
// on a final byte the class is decided from the advanced state and written
// into the result register. Throughput is one byte per cycle, set by the
// single recognizer update between the input and result registers, as long
// as no final byte has to wait behind a held result.
// Reset clears all token state and empties both registers. When the
// receiver stalls, the held result blocks only the next final byte; other
// bytes keep flowing, so one full token can stream in behind a stall.
// ----------------------------------------------------------------------------
`include "literal_token_classifier_unit_defines.svh"

module literal_token_classifier_unit (
    input logic      clk,
    input logic      rst_n,
    ltc_in_if.sink   tok,
    ltc_out_if.source res
);
    // Input register.
    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    logic       s1_go;

    // Token state.
    logic [ltc_pkg::TOK_LEN_W-1:0] tok_len_reg, tok_len_next;
    logic [7:0]                    open_reg, open_next;
    logic [1:0]                    logic_reg, logic_next;
    ltc_pkg::cx_phase_t            phase_reg, phase_next;
    ltc_pkg::seg_t                 whole_s, left_s, right_s;
    logic                          clr;
    logic                          feed_left, feed_right;
    logic [7:0]                    lc;

    // Result register.
    logic                out_valid_reg;
    ltc_pkg::lit_class_t cls_reg, cls_next;

    logic [1:0]              ev_whole, ev_left, ev_right;
    logic [ltc_pkg::LEN_W-1:0] nlen;

    // A final byte may only move when the result register is free.
    assign s1_go     = s1_valid_reg && (!s1_last_reg || !out_valid_reg || res.ready);
    assign tok.ready = !s1_valid_reg || s1_go;
    assign clr       = s1_go && s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (tok.ready)
            s1_valid_reg <= tok.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tok.ready && tok.valid)
        begin
            s1_char_reg <= tok.char_code;
            s1_last_reg <= tok.end_of_token;
        end
    end

    assign feed_left  = s1_go && phase_reg == ltc_pkg::PH_LEFT && s1_char_reg != ",";
    assign feed_right = s1_go && phase_reg == ltc_pkg::PH_RIGHT;

    ltc_seg u_whole (.clk(clk), .rst_n(rst_n), .feed(s1_go), .clear(clr),
                     .char_code(s1_char_reg), .seg_next(whole_s));
    ltc_seg u_left  (.clk(clk), .rst_n(rst_n), .feed(feed_left), .clear(clr),
                     .char_code(s1_char_reg), .seg_next(left_s));
    ltc_seg u_right (.clk(clk), .rst_n(rst_n), .feed(feed_right), .clear(clr),
                     .char_code(s1_char_reg), .seg_next(right_s));

    // Advance the simple token state by one byte.
    always_comb
    begin
        lc           = ltc_pkg::to_lower(s1_char_reg);
        tok_len_next = tok_len_reg;
        open_next    = open_reg;
        logic_next   = logic_reg;
        phase_next   = phase_reg;
        if (s1_go)
        begin
            if (tok_len_reg == '0)
                open_next = s1_char_reg;
            if (tok_len_reg >= 9'd6 || lc != ltc_pkg::true_char(tok_len_reg))
                logic_next[0] = 1'b0;
            if (tok_len_reg >= 9'd7 || lc != ltc_pkg::false_char(tok_len_reg))
                logic_next[1] = 1'b0;
            case (phase_reg)
                ltc_pkg::PH_FIRST:
                    phase_next = (s1_char_reg == "(") ? ltc_pkg::PH_LEFT : ltc_pkg::PH_NONE;
                ltc_pkg::PH_LEFT:
                    if (s1_char_reg == ",")
                        phase_next = ltc_pkg::PH_RIGHT;
                default:
                    phase_next = phase_reg;
            endcase
            if (tok_len_reg != '1)
                tok_len_next = tok_len_reg + 1'b1;
        end
    end

    // Decide the class from the state that includes the final byte.
    always_comb
    begin
        ev_whole = ltc_pkg::seg_eval(whole_s, 1'b0, 1'b0);
        ev_left  = ltc_pkg::seg_eval(left_s, 1'b0, 1'b1);
        ev_right = ltc_pkg::seg_eval(right_s, 1'b1, 1'b1);
        nlen     = whole_s.has_us ? whole_s.cut_len : whole_s.len;
        if ((logic_next[0] && tok_len_next == 9'd6) || (logic_next[1] && tok_len_next == 9'd7))
            cls_next = ltc_pkg::CLS_LOGICAL;
        else if (tok_len_next >= 9'd2 && (open_next == "\"" || open_next == "'") &&
                 s1_char_reg == open_next)
            cls_next = (tok_len_next >= 9'd4) ? ltc_pkg::CLS_STRING : ltc_pkg::CLS_CHAR;
        else if (phase_next == ltc_pkg::PH_RIGHT && s1_char_reg == ")" &&
                 left_s.len >= ltc_pkg::LEN_W'(1) &&
                 left_s.len <= ltc_pkg::LEN_W'(ltc_pkg::MAX_PART_LEN) &&
                 right_s.len >= ltc_pkg::LEN_W'(2) &&
                 right_s.len <= ltc_pkg::LEN_W'(ltc_pkg::MAX_PART_LEN + 1) &&
                 ev_left != 2'b00 && ev_right != 2'b00)
            cls_next = ltc_pkg::CLS_COMPLEX;
        else if (nlen <= ltc_pkg::LEN_W'(ltc_pkg::MAX_PART_LEN) && ev_whole[1])
            cls_next = ltc_pkg::CLS_REAL;
        else if (nlen <= ltc_pkg::LEN_W'(ltc_pkg::MAX_PART_LEN) && ev_whole[0])
            cls_next = ltc_pkg::CLS_INT;
        else
            cls_next = ltc_pkg::CLS_UNKNOWN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_len_reg   <= '0;
            open_reg      <= '0;
            logic_reg     <= 2'b11;
            phase_reg     <= ltc_pkg::PH_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                tok_len_reg <= '0;
                open_reg    <= '0;
                logic_reg   <= 2'b11;
                phase_reg   <= ltc_pkg::PH_FIRST;
            end
            else
            begin
                tok_len_reg <= tok_len_next;
                open_reg    <= open_next;
                logic_reg   <= logic_next;
                phase_reg   <= phase_next;
            end
            if (clr)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr)
            cls_reg <= cls_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.literal_class = cls_reg;

    // A new result only ever comes from a final byte moving on.
    `LTC_ASSERT_SAME(a_result_source, $rose(out_valid_reg), $past(s1_valid_reg && s1_last_reg))
    // Token state is empty right after a final byte.
    `LTC_ASSERT_NEXT(a_token_cleared, clr, tok_len_reg == '0 && phase_reg == ltc_pkg::PH_FIRST)
    // The complex phase only leaves its start once a byte has been counted.
    `LTC_ASSERT_SAME(a_phase_len, phase_reg != ltc_pkg::PH_FIRST, tok_len_reg != '0)
endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Literal token classifier testbench
// Streams directed and random tokens byte by byte into the classifier,
// predicts each token's class in a scoreboard and checks every result item
// against it, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ltc_pkg::*;

    typedef byte unsigned bytes_t[$];

    // State of one number recognizer: trailing whitespace seen, a '.' or 'e'
    // seen somewhere, and the syntax position.
    typedef struct {
        logic    trail;
        logic    mark;
        num_st_t st;
    } scan_t;

    // One scanned text: the running recognizer, its value one byte back,
    // its value at the last underscore, and the lengths.
    typedef struct {
        scan_t cur;
        scan_t back;
        scan_t at_us;
        bit    us_seen;
        int    len;
        int    us_len;
    } text_t;

    localparam int LEN_LIMIT = MAX_PART_LEN + 2;
    localparam int TOK_LIMIT = 511;
    localparam int CYCLE_LIMIT = 400000;

    // ------------------------------------------------------------------------
    // Class predictor and result checker.
    // ------------------------------------------------------------------------
    class class_checker;
        lit_class_t pending[$];
        int         errors;
        int         tok_len;
        byte unsigned first_byte;
        bit         true_ok;
        bit         false_ok;
        text_t      whole;
        cx_phase_t  phase;
        text_t      re_part;
        text_t      im_part;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            tok_len    = 0;
            first_byte = 0;
            true_ok    = 1;
            false_ok   = 1;
            whole      = blank();
            phase      = PH_FIRST;
            re_part    = blank();
            im_part    = blank();
        endfunction

        function text_t blank();
            text_t t;
            t.cur     = '{1'b0, 1'b0, N_START};
            t.back    = t.cur;
            t.at_us   = t.cur;
            t.us_seen = 0;
            t.len     = 0;
            t.us_len  = 0;
            return t;
        endfunction

        function byte unsigned lc(byte unsigned c);
            return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        endfunction

        function bit digit(byte unsigned c);
            return c >= "0" && c <= "9";
        endfunction

        function bit space(byte unsigned c);
            return c == " " || (c >= 9 && c <= 13);
        endfunction

        // First character of a number body, after any sign.
        function num_st_t body_start(byte unsigned c);
            if (c == "0") return N_ZERO;
            if (digit(c)) return N_DIG;
            if (c == ".") return N_DOT0;
            if (lc(c) == "i") return N_I1;
            if (lc(c) == "n") return N_N1;
            return N_DEAD;
        endfunction

        function scan_t step_scan(scan_t s, byte unsigned c);
            string   rest_of_inf;
            byte unsigned l;
            bit      d, hx, sg;
            scan_t   r;
            rest_of_inf = "nfinity";
            l  = lc(c);
            d  = digit(c);
            hx = d || (l >= "a" && l <= "f");
            sg = (c == "+" || c == "-");
            r  = s;
            if (c == "." || l == "e") r.mark = 1;
            if (s.st == N_DEAD) return r;
            if (s.trail) begin
                if (!space(c)) r.st = N_DEAD;
                return r;
            end
            if (space(c)) begin
                if (s.st != N_START) r.trail = 1;
                return r;
            end
            case (s.st)
                N_START: r.st = sg ? N_SIGN : body_start(c);
                N_SIGN:  r.st = body_start(c);
                N_ZERO:  r.st = d ? N_DIG : c == "." ? N_FRAC : l == "e" ? N_EXP
                              : l == "x" ? N_HX : N_DEAD;
                N_DIG:   r.st = d ? N_DIG : c == "." ? N_FRAC : l == "e" ? N_EXP : N_DEAD;
                N_DOT0:  r.st = d ? N_FRAC : N_DEAD;
                N_FRAC:  r.st = d ? N_FRAC : l == "e" ? N_EXP : N_DEAD;
                N_EXP:   r.st = sg ? N_ESGN : d ? N_EDIG : N_DEAD;
                N_ESGN, N_EDIG: r.st = d ? N_EDIG : N_DEAD;
                N_HX:    r.st = hx ? N_HINT : c == "." ? N_HDOT0 : N_DEAD;
                N_HDOT0: r.st = hx ? N_HFRAC : N_DEAD;
                N_HINT:  r.st = hx ? N_HINT : c == "." ? N_HFRAC : l == "p" ? N_HP : N_DEAD;
                N_HFRAC: r.st = hx ? N_HFRAC : l == "p" ? N_HP : N_DEAD;
                N_HP:    r.st = sg ? N_HPSGN : d ? N_HPDIG : N_DEAD;
                N_HPSGN, N_HPDIG: r.st = d ? N_HPDIG : N_DEAD;
                N_I1, N_I2, N_I3, N_I4, N_I5, N_I6, N_I7:
                    r.st = (l == rest_of_inf[s.st - N_I1]) ? num_st_t'(s.st + 1) : N_DEAD;
                N_N1:    r.st = l == "a" ? N_N2 : N_DEAD;
                N_N2:    r.st = l == "n" ? N_N3 : N_DEAD;
                N_N3:    r.st = c == "(" ? N_NP : N_DEAD;
                N_NP:    r.st = (d || (l >= "a" && l <= "z") || c == "_") ? N_NP
                              : c == ")" ? N_NC : N_DEAD;
                default: r.st = N_DEAD;
            endcase
            return r;
        endfunction

        function text_t feed(text_t t, byte unsigned c);
            if (c == "_") begin
                t.at_us   = t.cur;
                t.us_len  = t.len;
                t.us_seen = 1;
            end
            t.back = t.cur;
            t.cur  = step_scan(t.cur, c);
            if (t.len < LEN_LIMIT) t.len++;
            return t;
        endfunction

        // Bit 0 set for integer syntax, bit 1 for real syntax.
        function bit [1:0] judge(text_t t, bit one_back, bit trail_ok);
            scan_t    s;
            bit [1:0] r;
            r = 0;
            if (t.us_seen) begin
                s = t.at_us;
                trail_ok = 0;
            end else begin
                s = one_back ? t.back : t.cur;
            end
            if (s.trail && !trail_ok) return r;
            r[0] = (s.st == N_ZERO || s.st == N_DIG);
            r[1] = s.mark && (s.st inside {N_ZERO, N_DIG, N_FRAC, N_EDIG, N_HINT, N_HFRAC,
                                          N_HPDIG, N_I3, N_I8, N_N3, N_NC});
            return r;
        endfunction

        function lit_class_t decide(byte unsigned c);
            bit [1:0] v;
            int       nlen;
            nlen = whole.us_seen ? whole.us_len : whole.len;
            if ((true_ok && tok_len == 6) || (false_ok && tok_len == 7)) return CLS_LOGICAL;
            if (tok_len >= 2 && (first_byte == "\"" || first_byte == "'") && c == first_byte)
                return tok_len >= 4 ? CLS_STRING : CLS_CHAR;
            if (phase == PH_RIGHT && c == ")" && re_part.len >= 1
                && re_part.len <= MAX_PART_LEN && im_part.len >= 2
                && im_part.len <= MAX_PART_LEN + 1
                && judge(re_part, 0, 1) != 0 && judge(im_part, 1, 1) != 0)
                return CLS_COMPLEX;
            if (nlen <= MAX_PART_LEN) begin
                v = judge(whole, 0, 0);
                if (v[1]) return CLS_REAL;
                if (v[0]) return CLS_INT;
            end
            return CLS_UNKNOWN;
        endfunction

        // Advances the prediction by one accepted byte.
        function void note_byte(byte unsigned c, bit last);
            string tw, fw;
            tw = ".true.";
            fw = ".false.";
            if (tok_len == 0) first_byte = c;
            if (tok_len >= 6 || lc(c) != tw[tok_len]) true_ok = 0;
            if (tok_len >= 7 || lc(c) != fw[tok_len]) false_ok = 0;
            whole = feed(whole, c);
            case (phase)
                PH_FIRST: phase = (c == "(") ? PH_LEFT : PH_NONE;
                PH_LEFT:  if (c == ",") phase = PH_RIGHT; else re_part = feed(re_part, c);
                PH_RIGHT: im_part = feed(im_part, c);
                default:  ;
            endcase
            if (tok_len < TOK_LIMIT) tok_len++;
            if (last) begin
                pending.push_back(decide(c));
                clear();
            end
        endfunction

        function void check_class(logic [2:0] got);
            lit_class_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result item, class %0d", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: literal_class mismatch, expected %0d actual %0d",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    ltc_in_if  tok ();
    ltc_out_if res ();

    literal_token_classifier_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (tok),
        .res   (res)
    );

    class_checker board = new();
    bit     quiet = 0;
    int     cycles = 0;
    bytes_t stream_bytes;
    bit     stream_last[$];

    initial clk = 0;
    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // A run that stops making progress ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Results are taken from the pre-edge values of valid and ready.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            board.check_class(res.literal_class);
    end

    // The receiver stalls in random bursts until the quiet tail of the run.
    initial
    begin
        res.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Appends one token, with its final byte flagged.
    task automatic queue_token(bytes_t t);
        foreach (t[i])
        begin
            stream_bytes.push_back(t[i]);
            stream_last.push_back(i == t.size() - 1);
        end
    endtask

    function automatic bytes_t text(string s);
        bytes_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic bytes_t digits(int n);
        bytes_t q;
        repeat (n) q.push_back(8'("0" + $urandom_range(0, 9)));
        return q;
    endfunction

    function automatic byte unsigned mixed_case(byte unsigned c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1)) return c - 8'd32;
        return c;
    endfunction

    // A number in one of the integer or real forms, sometimes padded with
    // whitespace, signed, or given a kind suffix.
    function automatic bytes_t random_number();
        bytes_t q;
        string  hexd;
        hexd = "0123456789abcdefABCDEF";
        if ($urandom_range(0, 5) == 0) q.push_back(" ");
        if ($urandom_range(0, 3) == 0) q.push_back($urandom_range(0, 1) ? "-" : "+");
        case ($urandom_range(0, 7))
            0, 1: q = {q, digits($urandom_range(1, 5))};
            2:    q = {q, digits($urandom_range(0, 3)), text("."), digits($urandom_range(0, 3))};
            3:
            begin
                q = {q, digits($urandom_range(1, 3))};
                q.push_back($urandom_range(0, 1) ? "e" : "E");
                if ($urandom_range(0, 1)) q.push_back("-");
                q = {q, digits($urandom_range(0, 2))};
            end
            4:
            begin
                q = {q, text($urandom_range(0, 1) ? "0x" : "0X")};
                repeat ($urandom_range(1, 3)) q.push_back(hexd[$urandom_range(0, 21)]);
                if ($urandom_range(0, 1)) q = {q, text(".8")};
                if ($urandom_range(0, 1)) q = {q, text("p"), digits($urandom_range(0, 2))};
            end
            5:
            begin
                bytes_t w;
                w = text($urandom_range(0, 1) ? "inf" : "infinity");
                if ($urandom_range(0, 3) == 0) void'(w.pop_back());
                foreach (w[i]) q.push_back(mixed_case(w[i]));
            end
            6:
            begin
                q = {q, text("nan")};
                if ($urandom_range(0, 1)) q = {q, text("(a_1"), digits(1), text(")")};
            end
            default: q = {q, digits(1), text("."), digits(2), text("e+"), digits(1)};
        endcase
        if ($urandom_range(0, 4) == 0) q = {q, text($urandom_range(0, 1) ? "_dp" : "_8")};
        if ($urandom_range(0, 5) == 0) q.push_back($urandom_range(0, 1) ? " " : "\t");
        return q;
    endfunction

    function automatic bytes_t random_token();
        bytes_t q;
        case ($urandom_range(0, 9))
            0, 1, 2: q = random_number();
            3, 4:
            begin
                q = {text("("), random_number(), text(","), random_number(), text(")")};
            end
            5:
            begin
                byte unsigned quote;
                quote = $urandom_range(0, 1) ? "\"" : "'";
                q.push_back(quote);
                repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(32, 126)));
                q.push_back($urandom_range(0, 5) == 0 ? "\"" : quote);
            end
            6:
            begin
                bytes_t w;
                w = text($urandom_range(0, 1) ? ".true." : ".false.");
                foreach (w[i]) q.push_back(mixed_case(w[i]));
                if ($urandom_range(0, 3) == 0) q[$urandom_range(0, q.size() - 1)] = "x";
            end
            7:  repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
            8:  q.push_back(8'($urandom_range(0, 255)));
            default:
            begin
                // Broken number or complex: one byte replaced at random.
                q = $urandom_range(0, 1) ? random_number()
                    : {text("("), random_number(), text(","), random_number(), text(")")};
                q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
            end
        endcase
        return q;
    endfunction

    // Offers one byte and waits until it is taken.
    task automatic send_byte(byte unsigned c, bit last);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            tok.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        tok.valid        <= 1'b1;
        tok.char_code    <= c;
        tok.end_of_token <= last;
        do @(posedge clk); while (!tok.ready);
        board.note_byte(c, last);
    endtask

    initial
    begin
        bytes_t t;
        rst_n            <= 1'b0;
        tok.valid        <= 1'b0;
        tok.char_code    <= 8'h00;
        tok.end_of_token <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed tokens: logical words in both cases, quoted literals of
        // every length class, complex pairs, each number form, the kind
        // suffix, inner whitespace, zero and high bytes, and overlong text.
        queue_token(text(".true."));
        queue_token(text(".FaLsE."));
        queue_token(text(".tru."));
        queue_token(text("'a'"));
        queue_token(text("\"ab\""));
        queue_token(text("''"));
        queue_token(text("\""));
        queue_token(text("'ab\""));
        queue_token(text("(1,2)"));
        queue_token(text("( 1.5e3 , -2_dp )"));
        queue_token(text("(1,)"));
        queue_token(text("(,1)"));
        queue_token(text("0x1.8p-3"));
        queue_token(text("-INFINITY"));
        queue_token(text("nan(ab_1)"));
        queue_token(text(" +42"));
        queue_token(text("1 2"));
        queue_token(text("12 _8"));
        queue_token(text("1.5_dp"));
        queue_token(text("7_a_b"));
        t = {8'h00};
        queue_token(t);
        t = {8'hff};
        queue_token(t);
        queue_token(digits(MAX_PART_LEN));
        queue_token(digits(MAX_PART_LEN + 1));
        queue_token({text("("), digits(MAX_PART_LEN + 1), text(",1)")});
        queue_token({digits(300), text("_8")});

        // Random tokens fill the stream up to its planned length.
        while (stream_bytes.size() < 1500)
            queue_token(random_token());

        while (stream_bytes.size() > 0)
        begin
            if (stream_bytes.size() < 150) quiet = 1;
            send_byte(stream_bytes.pop_front(), stream_last.pop_front());
        end
        tok.valid <= 1'b0;

        // Drain outstanding results, then allow for the pipeline latency.
        while (board.pending.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ltc_pkg.sv
rtl/core/ltc_in_if.sv
rtl/core/ltc_out_if.sv
rtl/core/ltc_seg.sv
rtl/core/literal_token_classifier_unit.sv
verif/testbench.sv
